// File: sv/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the substring match splitter.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default sizing
  localparam int unsigned MAX_PATTERN_DEF   = 8;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Field widths fixed by the register map and the result item
  localparam int unsigned PATTERN_W   = 64;
  localparam int unsigned LENGTH_W    = 4;
  localparam int unsigned MATCH_POS_W = 16;
  localparam int unsigned BYTE_W      = 8;

  // Configuration port: 64-bit registers at 8-byte spacing
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_CASE    = 2'd2;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_bytes;
    logic [LENGTH_W-1:0]  pattern_length;
    logic                 ignore_case;
  } cfg_t;

endpackage

// File: sv/ssm_text_if.sv
// ----------------------------------------------------------------------------
// ssm_text_if
// Text byte channel: one byte per item, with an end-of-text marker.
// ----------------------------------------------------------------------------
interface ssm_text_if;
  logic                        valid;
  logic                        ready;
  logic [ssm_pkg::BYTE_W-1:0]  text_byte;
  logic                        text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// File: sv/ssm_result_if.sv
// ----------------------------------------------------------------------------
// ssm_result_if
// Result channel: match report and end-of-text status.
// ----------------------------------------------------------------------------
interface ssm_result_if;
  logic                            valid;
  logic                            ready;
  logic                            match_found;
  logic [ssm_pkg::MATCH_POS_W-1:0] match_position;
  logic                            end_of_text;
  logic                            position_overflow;

  modport source (output valid, output match_found, output match_position,
                  output end_of_text, output position_overflow, input ready);
  modport sink   (input valid, input match_found, input match_position,
                  input end_of_text, input position_overflow, output ready);
endinterface

// File: sv/substring_match_splitter_core.sv
// ----------------------------------------------------------------------------
// substring_match_splitter_core
// Streaming split-style separator search over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   text_i carries one text byte per item, text_last marking the final byte.
//   match_o carries a result item for each byte that ends a match and for the
//   final byte of each text; other bytes produce no result. A match reports
//   the start offset of the occurrence; after a match the search restarts at
//   the following byte, so matches never overlap.
//   The APB port holds the pattern (up to MAX_PATTERN bytes), its length and
//   the ASCII case-folding switch. Write it only while no text is in flight.
// Timing:
//   One byte per cycle while match_o does not stall. A result is registered
//   and appears on match_o in the cycle after its byte is accepted. The window
//   compare for every pattern length runs in parallel in the cycle the byte is
//   accepted; the result register is the only stage.
// Reset:
//   Clears the window, the restart count, the position, the overflow flag and
//   the result valid flag; the pattern resets to one zero byte.
// Stalls:
//   While a result waits and match_o.ready is low, text_i.ready drops; a
//   byte is still taken in the cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module substring_match_splitter_core #(
  parameter int unsigned MAX_PATTERN   = ssm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = ssm_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ssm_text_if.sink                       text_i,
  ssm_result_if.source                   match_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned WIN_W = 8 * MAX_PATTERN;
  localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned WIDE_W = 32;

  ssm_pkg::cfg_t cfg;

  // Search state
  logic [WIN_W-1:0]         win_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic                     ovf_q;

  // Result register
  logic                            out_valid_q;
  logic                            out_found_q;
  logic [ssm_pkg::MATCH_POS_W-1:0] out_pos_q;
  logic                            out_last_q;
  logic                            out_ovf_q;

  logic                            accept;
  logic [ssm_pkg::LENGTH_W-1:0]    act_len;
  logic [WIN_W-1:0]                win_nxt;
  logic [CNT_W-1:0]                cnt_inc;
  logic                            pos_top;
  logic [POSITION_BITS-1:0]        pos_nxt;
  logic                            ovf_nxt;
  logic                            win_hit;
  logic                            found;
  logic [POSITION_BITS-1:0]        back;
  logic [POSITION_BITS-1:0]        start;
  logic [WIDE_W-1:0]               start_wide;
  logic                            start_clip;
  logic [ssm_pkg::MATCH_POS_W-1:0] start_rep;

  ssm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take a byte whenever the result register is empty or draining
  assign text_i.ready = !out_valid_q || match_o.ready;
  assign accept       = text_i.valid && text_i.ready;

  // Clamp length: zero acts as one, anything above the window acts as full
  always_comb begin
    act_len = cfg.pattern_length;
    if (act_len == '0) act_len = ssm_pkg::LENGTH_W'(1);
    if (act_len > ssm_pkg::LENGTH_W'(MAX_PATTERN)) act_len = ssm_pkg::LENGTH_W'(MAX_PATTERN);
  end

  // Shift the new byte into the window
  assign win_nxt = (win_q << 8) | WIN_W'(text_i.text_byte);
  assign cnt_inc = (cnt_q < CNT_W'(MAX_PATTERN)) ? cnt_q + CNT_W'(1) : cnt_q;

  // Position saturates at all ones and flags overflow from then on
  assign pos_top = &pos_q;
  assign pos_nxt = pos_top ? pos_q : pos_q + POSITION_BITS'(1);
  assign ovf_nxt = ovf_q | pos_top;

  ssm_window_cmp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window_cmp (
    .pattern_i     (cfg.pattern_bytes),
    .ignore_case_i (cfg.ignore_case),
    .window_i      (win_nxt),
    .length_i      (act_len),
    .hit_o         (win_hit)
  );

  assign found = (ssm_pkg::LENGTH_W'(cnt_inc) >= act_len) && win_hit;

  // Start offset of the match, held at zero when the text is shorter
  assign back  = POSITION_BITS'(act_len - ssm_pkg::LENGTH_W'(1));
  assign start = (pos_q >= back) ? pos_q - back : '0;

  // Clip to the result field width
  assign start_wide = WIDE_W'(start);
  assign start_clip = found && (|start_wide[WIDE_W-1:ssm_pkg::MATCH_POS_W]);
  assign start_rep  = !found ? '0 :
                      start_clip ? '1 : start_wide[ssm_pkg::MATCH_POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (text_i.text_last) begin
        // Start over for the next text
        win_q <= '0;
        cnt_q <= '0;
        pos_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        win_q <= win_nxt;
        cnt_q <= found ? '0 : cnt_inc;
        pos_q <= pos_nxt;
        ovf_q <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= found || text_i.text_last;
    end else if (match_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_found_q <= found;
      out_pos_q   <= start_rep;
      out_last_q  <= text_i.text_last;
      out_ovf_q   <= ovf_nxt || start_clip;
    end
  end

  assign match_o.valid             = out_valid_q;
  assign match_o.match_found       = out_found_q;
  assign match_o.match_position    = out_pos_q;
  assign match_o.end_of_text       = out_last_q;
  assign match_o.position_overflow = out_ovf_q;

  // Overflow is only ever flagged with the position pinned at its top
  a_ovf_pinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (&pos_q))
    else $error("overflow flag set below position top");

  // The restart count never passes the window depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PATTERN))
    else $error("restart count out of range");

  // End of text clears the search state
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && text_i.text_last) |=> (pos_q == '0 && cnt_q == '0 && !ovf_q && win_q == '0))
    else $error("state not cleared after end of text");

  // A match restarts the search
  a_match_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && found) |=> (cnt_q == '0 && out_valid_q && out_found_q))
    else $error("match did not restart the search");

  // No byte is taken while a waiting result is held
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !match_o.ready) |-> !accept)
    else $error("byte accepted over a held result");

endmodule

// File: sv/ssm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssm_cfg_regs
// APB register file: pattern bytes, pattern length, case folding.
// ----------------------------------------------------------------------------
module ssm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ssm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ssm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output ssm_pkg::cfg_t                    cfg_o
);

  ssm_pkg::cfg_t                   cfg_q;
  logic                            wr_en;
  logic [ssm_pkg::REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ssm_pkg::APB_ADDR_W-1:3];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes  <= '0;
      cfg_q.pattern_length <= ssm_pkg::LENGTH_W'(1);
      cfg_q.ignore_case    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        ssm_pkg::REG_PATTERN_BYTES: begin
          cfg_q.pattern_bytes <= pwdata[ssm_pkg::PATTERN_W-1:0];
        end
        ssm_pkg::REG_PATTERN_LENGTH: begin
          cfg_q.pattern_length <= pwdata[ssm_pkg::LENGTH_W-1:0];
        end
        ssm_pkg::REG_IGNORE_CASE: begin
          cfg_q.ignore_case <= pwdata[0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ssm_pkg::REG_PATTERN_BYTES:  prdata = cfg_q.pattern_bytes;
      ssm_pkg::REG_PATTERN_LENGTH: prdata = ssm_pkg::APB_DATA_W'(cfg_q.pattern_length);
      ssm_pkg::REG_IGNORE_CASE:    prdata = ssm_pkg::APB_DATA_W'(cfg_q.ignore_case);
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: sv/ssm_window_cmp.sv
// ----------------------------------------------------------------------------
// ssm_window_cmp
// Parallel compare of the byte window against the pattern, all lengths at once.
// ----------------------------------------------------------------------------
module ssm_window_cmp #(
  parameter int unsigned MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEF
) (
  input  logic [ssm_pkg::PATTERN_W-1:0]  pattern_i,
  input  logic                           ignore_case_i,
  input  logic [8*MAX_PATTERN-1:0]       window_i,   // newest byte in [7:0]
  input  logic [ssm_pkg::LENGTH_W-1:0]   length_i,   // already clamped
  output logic                           hit_o
);

  logic [7:0]             pat_f [MAX_PATTERN];
  logic [7:0]             win_f [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_len;
  logic [MAX_PATTERN-1:0] len_sel;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
    logic [7:0] r;
    r = b;
    if (ic && b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_f[i] = fold(pattern_i[8*i +: 8], ignore_case_i);
      win_f[i] = fold(window_i[8*i +: 8], ignore_case_i);
    end
  end

  // Length l+1 matches when pattern byte i equals window byte l-i for all i <= l
  for (genvar l = 0; l < MAX_PATTERN; l++) begin : g_len
    logic [l:0] eq;
    for (genvar i = 0; i <= l; i++) begin : g_byte
      assign eq[i] = (pat_f[i] == win_f[l-i]);
    end
    assign hit_len[l] = &eq;
    assign len_sel[l] = (length_i == ssm_pkg::LENGTH_W'(l + 1));
  end

  assign hit_o = |(hit_len & len_sel);

endmodule

// File: tb/substring_match_splitter_core_test.sv
// ----------------------------------------------------------------------------
// substring_match_splitter_core_test
// Self-checking bench for the streaming split-style separator search.
// ----------------------------------------------------------------------------
// A driver feeds text bytes from a queue and a monitor takes result items,
// both with random wait cycles. Every accepted text byte runs through a
// behavioral scanner that tracks the window, the restart count, the position
// and the overflow flag; each result the scanner predicts is queued and
// compared field by field with what the block returns. The pattern, its
// length and the case-folding switch change over the APB port between
// phases, sometimes in the middle of an open text.
// ----------------------------------------------------------------------------
module substring_match_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1600;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned LONG_TEXT_LEN = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned MAX_WAIT      = 6;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned POS_TOP       = (1 << ssm_pkg::POSITION_BITS_DEF) - 1;

  typedef struct packed {
    logic [ssm_pkg::BYTE_W-1:0] value;
    logic                       is_last;
  } text_item_t;

  typedef struct packed {
    logic                            found;
    logic [ssm_pkg::MATCH_POS_W-1:0] start;
    logic                            eot;
    logic                            ovf;
  } match_item_t;

  // Clock, reset, and the APB port
  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ssm_pkg::APB_ADDR_W-1:0] paddr;
  logic [ssm_pkg::APB_DATA_W-1:0] pwdata;
  logic [ssm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  ssm_text_if   txt ();
  ssm_result_if res ();

  substring_match_splitter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (txt),
    .match_o (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Mirror of the configuration registers, reset values included
  logic [ssm_pkg::PATTERN_W-1:0] pat_mirror  = '0;
  logic [ssm_pkg::LENGTH_W-1:0]  len_mirror  = ssm_pkg::LENGTH_W'(1);
  logic                          fold_mirror = 1'b0;

  // Scanner state: raw window (newest byte low), bytes since the text start or
  // the last match, offset of the next byte, and the sticky overflow flag
  logic [ssm_pkg::PATTERN_W-1:0] window        = '0;
  int unsigned                   since_restart = 0;
  int unsigned                   next_pos      = 0;
  bit                            pos_saturated = 1'b0;

  text_item_t  text_q[$];
  match_item_t match_expect_q[$];

  int unsigned pushed_items = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_wait    = 0;
  int unsigned send_calm    = 0;
  int unsigned recv_wait    = 0;
  int unsigned recv_calm    = 0;

  // --------------------------------------------------------------------------
  // Scanner
  // --------------------------------------------------------------------------

  // Clamp the length register the way the block does: 0 acts as 1, anything
  // above the window size acts as the window size.
  function automatic int unsigned eff_length();
    int unsigned n;
    n = len_mirror;
    if (n < 1) n = 1;
    if (n > ssm_pkg::MAX_PATTERN_DEF) n = ssm_pkg::MAX_PATTERN_DEF;
    return n;
  endfunction

  function automatic logic [ssm_pkg::BYTE_W-1:0] fold_ascii(
    input logic [ssm_pkg::BYTE_W-1:0] b);
    if (fold_mirror && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  // Advance the scanner by one text byte. Return 1 when the byte produces a
  // result item, which lands in r.
  function automatic bit scan_byte(input logic [ssm_pkg::BYTE_W-1:0] b,
                                   input logic is_last,
                                   output match_item_t r);
    int unsigned n;
    int unsigned cur;
    int unsigned start;
    bit          hit;
    n     = eff_length();
    cur   = next_pos;
    hit   = 1'b0;
    start = 0;
    // Hold the offset at the counter top and flag it for the rest of the text
    if (cur >= POS_TOP) begin
      cur           = POS_TOP;
      pos_saturated = 1'b1;
    end else begin
      next_pos = cur + 1;
    end
    window = {window[ssm_pkg::PATTERN_W-ssm_pkg::BYTE_W-1:0], b};
    if (since_restart < ssm_pkg::MAX_PATTERN_DEF) since_restart++;
    // Compare only once enough bytes arrived since the last restart; the
    // window holds raw bytes, so fold both sides with the current setting
    if (since_restart >= n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (fold_ascii(pat_mirror[8*i +: 8]) != fold_ascii(window[8*(n-1-i) +: 8]))
          hit = 1'b0;
      end
    end
    if (hit) begin
      start         = (cur >= n - 1) ? cur - (n - 1) : 0;
      since_restart = 0;
    end
    r.found = hit;
    r.start = ssm_pkg::MATCH_POS_W'(start);
    r.eot   = is_last;
    r.ovf   = pos_saturated;
    // Drop all text state after the final byte
    if (is_last) begin
      window        = '0;
      since_restart = 0;
      next_pos      = 0;
      pos_saturated = 1'b0;
    end
    return hit || is_last;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------

  // Draw the wait before the next item; now and then start a stretch of
  // items with no waits at all.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(30, 200);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_error(input string what);
    err_count++;
    if (err_count <= PRINT_CAP) $display("[%0t] ERROR %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Text driver: present the next queued item once the wait drawn after the
  // previous one has run out; hold the item until it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    match_item_t r;
    text_item_t  item;
    if (!rst_ni) begin
      txt.valid     <= 1'b0;
      txt.text_byte <= '0;
      txt.text_last <= 1'b0;
      send_wait     <= 0;
    end else begin
      // Predict on the item taken at this edge
      if (txt.valid && txt.ready) begin
        if (scan_byte(txt.text_byte, txt.text_last, r)) match_expect_q.push_back(r);
      end
      if (!txt.valid || txt.ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          txt.valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          item = text_q.pop_front();
          txt.valid     <= 1'b1;
          txt.text_byte <= item.value;
          txt.text_last <= item.is_last;
          send_wait     <= draw_wait(send_calm);
        end else begin
          txt.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each taken item against the oldest expectation,
  // then drop ready for the wait drawn for the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    match_item_t want;
    int unsigned n;
    if (!rst_ni) begin
      res.ready <= 1'b0;
      recv_wait <= 0;
    end else if (res.valid && res.ready) begin
      if (match_expect_q.size() == 0) begin
        report_error("result item with no expectation waiting");
      end else begin
        want = match_expect_q.pop_front();
        if (res.match_found !== want.found)
          report_error($sformatf("match_found got %0d want %0d", res.match_found, want.found));
        if (res.match_position !== want.start)
          report_error($sformatf("match_position got %0d want %0d",
                                 res.match_position, want.start));
        if (res.end_of_text !== want.eot)
          report_error($sformatf("end_of_text got %0d want %0d", res.end_of_text, want.eot));
        if (res.position_overflow !== want.ovf)
          report_error($sformatf("position_overflow got %0d want %0d",
                                 res.position_overflow, want.ovf));
      end
      n = draw_wait(recv_calm);
      recv_wait <= n;
      res.ready <= (n == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      res.ready <= (recv_wait == 1);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle until pready; update the
  // mirror at the edge that writes the register.
  task automatic write_reg(input logic [ssm_pkg::REG_IDX_W-1:0] idx,
                           input logic [ssm_pkg::APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ssm_pkg::REG_PATTERN_BYTES:  pat_mirror  = value[ssm_pkg::PATTERN_W-1:0];
      ssm_pkg::REG_PATTERN_LENGTH: len_mirror  = value[ssm_pkg::LENGTH_W-1:0];
      ssm_pkg::REG_IGNORE_CASE:    fold_mirror = value[0];
      default: ;
    endcase
  endtask

  // Hold until nothing is queued, in flight or expected, then let the block
  // settle before touching its registers.
  task automatic wait_idle();
    while (text_q.size() != 0 || txt.valid || match_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [ssm_pkg::BYTE_W-1:0] b, input logic is_last);
    text_q.push_back('{value: b, is_last: is_last});
    pushed_items++;
  endtask

  // Build one text from tokens: whole pattern copies (case flipped at random,
  // or as a near miss when folding is off), cut-off prefixes ending in a
  // random byte, and noise bytes. Close it with the end marker if asked.
  task automatic add_text(input int unsigned tokens, input bit close);
    int unsigned                n;
    int unsigned                pick;
    int unsigned                k;
    logic [ssm_pkg::BYTE_W-1:0] b;
    logic [ssm_pkg::BYTE_W-1:0] bytes_q[$];
    n = eff_length();
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        for (int i = 0; i < n; i++) begin
          b = pat_mirror[8*i +: 8];
          if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
              $urandom_range(0, fold_mirror ? 1 : 7) == 0)
            b ^= 8'h20;
          bytes_q.push_back(b);
        end
      end else if (pick < 75) begin
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < k; i++) bytes_q.push_back(pat_mirror[8*i +: 8]);
        bytes_q.push_back(ssm_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          bytes_q.push_back(ssm_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
    foreach (bytes_q[i]) push_byte(bytes_q[i], close && (i == bytes_q.size() - 1));
  endtask

  // Pick a new setting: pattern bytes lean on letters and the bytes next to
  // the letter ranges; length is mostly legal but sometimes 0 or above 8;
  // upper bits of the narrow registers carry noise.
  task automatic random_config();
    logic [ssm_pkg::PATTERN_W-1:0]  pat;
    logic [ssm_pkg::APB_DATA_W-1:0] lenv;
    logic [ssm_pkg::APB_DATA_W-1:0] foldv;
    int unsigned                    sel;
    for (int i = 0; i < ssm_pkg::MAX_PATTERN_DEF; i++) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: pat[8*i +: 8] = ssm_pkg::BYTE_W'($urandom_range(0, 255));
        1: pat[8*i +: 8] = ssm_pkg::BYTE_W'($urandom_range(8'h41, 8'h5A));
        2: pat[8*i +: 8] = ssm_pkg::BYTE_W'($urandom_range(8'h61, 8'h7A));
        default: begin
          case ($urandom_range(0, 3))
            0: pat[8*i +: 8] = 8'h40;
            1: pat[8*i +: 8] = 8'h5B;
            2: pat[8*i +: 8] = 8'h60;
            default: pat[8*i +: 8] = 8'h7B;
          endcase
        end
      endcase
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) pat = '0;
    if (sel == 1) pat = '1;
    lenv = '0;
    if ($urandom_range(0, 3) == 0) lenv = {$urandom(), $urandom()};
    if ($urandom_range(0, 7) == 0)
      lenv[ssm_pkg::LENGTH_W-1:0] = ($urandom_range(0, 1) != 0) ?
                                    ssm_pkg::LENGTH_W'($urandom_range(9, 15)) : '0;
    else
      lenv[ssm_pkg::LENGTH_W-1:0] =
        ssm_pkg::LENGTH_W'($urandom_range(1, ssm_pkg::MAX_PATTERN_DEF));
    foldv = {$urandom(), $urandom()};
    write_reg(ssm_pkg::REG_PATTERN_BYTES, pat);
    write_reg(ssm_pkg::REG_PATTERN_LENGTH, lenv);
    write_reg(ssm_pkg::REG_IGNORE_CASE, foldv);
  endtask

  initial begin
    int unsigned                random_start;
    int unsigned                phase_start;
    logic [ssm_pkg::BYTE_W-1:0] sep [3];

    // Drive the reset and the APB port to a known value from time zero
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting (one zero byte): a one-byte match on the final byte too
    push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b1);

    // "abab" over "ababab": the overlapping second hit must not be reported
    wait_idle();
    write_reg(ssm_pkg::REG_PATTERN_BYTES, 64'h0000_0000_6261_6261);
    write_reg(ssm_pkg::REG_PATTERN_LENGTH, 64'd4);
    write_reg(ssm_pkg::REG_IGNORE_CASE, 64'd0);
    for (int i = 0; i < 6; i++) push_byte((i % 2 == 0) ? 8'h61 : 8'h62, i == 5);

    // Case folding on "Zb@": mixed case matches, '`' must not fold onto '@'
    wait_idle();
    write_reg(ssm_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0040_625A);
    write_reg(ssm_pkg::REG_PATTERN_LENGTH, 64'd3);
    write_reg(ssm_pkg::REG_IGNORE_CASE, 64'd1);
    push_byte(8'h7A, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h60, 1'b1);

    // Length zero acts as one, all-ones pattern
    wait_idle();
    write_reg(ssm_pkg::REG_PATTERN_BYTES, '1);
    write_reg(ssm_pkg::REG_PATTERN_LENGTH, 64'd0);
    write_reg(ssm_pkg::REG_IGNORE_CASE, 64'd0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b1);

    // Length 15 acts as the full eight-byte window
    wait_idle();
    write_reg(ssm_pkg::REG_PATTERN_LENGTH, 64'd15);
    for (int i = 0; i < 9; i++) push_byte(8'hFF, i == 8);

    // One longer text with "xyz" separators scattered between noise bytes
    wait_idle();
    write_reg(ssm_pkg::REG_PATTERN_BYTES, 64'h0000_0000_007A_7978);
    write_reg(ssm_pkg::REG_PATTERN_LENGTH, 64'd3);
    sep[0] = 8'h78;
    sep[1] = 8'h79;
    sep[2] = 8'h7A;
    for (int i = 0; i < LONG_TEXT_LEN; i++) begin
      if (i % 50 < 3) push_byte(sep[i % 50], i == LONG_TEXT_LEN - 1);
      else push_byte(ssm_pkg::BYTE_W'($urandom_range(0, 255)), i == LONG_TEXT_LEN - 1);
    end

    // Random phases; the last text of a phase stays open now and then, so
    // the next setting lands in the middle of it
    random_start = pushed_items;
    while (pushed_items - random_start < RANDOM_ITEMS) begin
      wait_idle();
      random_config();
      phase_start = pushed_items;
      while (pushed_items - phase_start < PHASE_ITEMS) add_text($urandom_range(1, 8), 1'b1);
      add_text($urandom_range(1, 4), $urandom_range(0, 4) != 0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
